// ===== hdl/lwm_pkg.sv =====
// ----------------------------------------------------------------------------
// lwm_pkg
// Shared constants and request/response types for the LIKE wildcard matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package lwm_pkg;

   localparam int MAX_PATTERN_LEN = 64;
   localparam int MAX_VALUE_LEN   = 256;

   localparam int PLEN_W  = $clog2(MAX_PATTERN_LEN + 1);
   localparam int VLEN_W  = $clog2(MAX_VALUE_LEN + 1);
   localparam int PADDR_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
   localparam int VADDR_W = (MAX_VALUE_LEN > 1) ? $clog2(MAX_VALUE_LEN) : 1;

   localparam logic [7:0] CH_ANY_RUN = 8'h25;
   localparam logic [7:0] CH_ANY_ONE = 8'h5F;

   localparam logic REQ_PATTERN = 1'b0;
   localparam logic REQ_VALUE   = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] char_byte;
      logic       no_char;
      logic       last;
   } lwm_req_type;

   typedef struct packed {
      logic matched;
      logic too_long;
   } lwm_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/like_wildcard_match.sv =====
// ----------------------------------------------------------------------------
// like_wildcard_match
// SQL LIKE matcher: pattern and value strings load one character per request;
// the closing value request runs a greedy walk with one backtrack point.
// ----------------------------------------------------------------------------
// Every pattern request and every value request that is not the last one is
// taken while the block stays idle, so busy stays low and characters can
// stream back to back. The last value request starts the match walk, which
// reads one pattern and one value character per step from the two stores;
// each step has an address state (FETCH), then a compare state (EVAL) on the
// registered read data. The number of steps is at most about
// (value_length + 1) * (pattern_length + 1) when backtracking at the latest
// '%' repeats. If either store overflowed, the last value request answers in
// the cycle after it is taken, with no walk. The result is shown on rsp_data
// with rsp_strobe high for a single cycle; the receiver cannot stall it, and
// busy is already low in that cycle.
`default_nettype none

module like_wildcard_match (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   output logic                      busy,
   input  wire lwm_pkg::lwm_req_type req_data,
   output logic                      rsp_strobe,
   output lwm_pkg::lwm_rsp_type      rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EVAL
   } state_type;

   state_type state_ff;

   logic [7:0] pat_mem [lwm_pkg::MAX_PATTERN_LEN];
   logic [7:0] val_mem [lwm_pkg::MAX_VALUE_LEN];
   logic [7:0] pat_rd_ff;
   logic [7:0] val_rd_ff;

   logic [lwm_pkg::PLEN_W-1:0] plen_ff;
   logic                       povf_ff;
   logic                       pclosed_ff;
   logic [lwm_pkg::VLEN_W-1:0] vlen_ff;
   logic                       vovf_ff;

   logic [lwm_pkg::PLEN_W-1:0] pi_ff;
   logic [lwm_pkg::VLEN_W-1:0] vi_ff;
   logic [lwm_pkg::PLEN_W-1:0] pmark_ff;
   logic [lwm_pkg::VLEN_W-1:0] vmark_ff;
   logic                       marked_ff;

   logic                 rsp_strobe_ff;
   lwm_pkg::lwm_rsp_type rsp_ff;

   logic                       accept;
   logic [lwm_pkg::PLEN_W-1:0] plen_base;
   logic                       povf_base;
   logic                       pat_we;
   logic                       val_we;
   logic                       pat_room;
   logic                       val_room;
   logic                       vovf_new;

   logic                       p_in_range;
   logic                       v_in_range;
   logic                       pc_is_run;
   logic                       pc_fits;

   assign accept    = start && (state_ff == ST_IDLE);
   assign plen_base = pclosed_ff ? '0 : plen_ff;
   assign povf_base = pclosed_ff ? 1'b0 : povf_ff;
   assign pat_room  = plen_base < lwm_pkg::PLEN_W'(lwm_pkg::MAX_PATTERN_LEN);
   assign val_room  = vlen_ff < lwm_pkg::VLEN_W'(lwm_pkg::MAX_VALUE_LEN);
   assign pat_we    = accept && (req_data.req_type == lwm_pkg::REQ_PATTERN)
                      && !req_data.no_char && pat_room;
   assign val_we    = accept && (req_data.req_type == lwm_pkg::REQ_VALUE)
                      && !req_data.no_char && val_room;
   assign vovf_new  = vovf_ff || (!req_data.no_char && !val_room);

   assign p_in_range = pi_ff < plen_ff;
   assign v_in_range = vi_ff < vlen_ff;
   assign pc_is_run  = p_in_range && (pat_rd_ff == lwm_pkg::CH_ANY_RUN);
   assign pc_fits    = p_in_range && ((pat_rd_ff == lwm_pkg::CH_ANY_ONE)
                                      || (pat_rd_ff == val_rd_ff));

   // character stores
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[plen_base[lwm_pkg::PADDR_W-1:0]] <= req_data.char_byte;
      end
      pat_rd_ff <= pat_mem[pi_ff[lwm_pkg::PADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[vlen_ff[lwm_pkg::VADDR_W-1:0]] <= req_data.char_byte;
      end
      val_rd_ff <= val_mem[vi_ff[lwm_pkg::VADDR_W-1:0]];
   end

   // load control and match sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         plen_ff       <= '0;
         povf_ff       <= 1'b0;
         pclosed_ff    <= 1'b1;
         vlen_ff       <= '0;
         vovf_ff       <= 1'b0;
         pi_ff         <= '0;
         vi_ff         <= '0;
         pmark_ff      <= '0;
         vmark_ff      <= '0;
         marked_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_ff        <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_data.req_type == lwm_pkg::REQ_PATTERN)) begin
                  plen_ff    <= plen_base + lwm_pkg::PLEN_W'(pat_we);
                  povf_ff    <= povf_base || (!req_data.no_char && !pat_room);
                  pclosed_ff <= req_data.last;
               end else if (accept) begin
                  if (!req_data.last) begin
                     vlen_ff <= vlen_ff + lwm_pkg::VLEN_W'(val_we);
                     vovf_ff <= vovf_new;
                  end else if (povf_ff || vovf_new) begin
                     rsp_strobe_ff   <= 1'b1;
                     rsp_ff.matched  <= 1'b0;
                     rsp_ff.too_long <= 1'b1;
                     vlen_ff         <= '0;
                     vovf_ff         <= 1'b0;
                  end else begin
                     vlen_ff   <= vlen_ff + lwm_pkg::VLEN_W'(val_we);
                     vovf_ff   <= 1'b0;
                     pi_ff     <= '0;
                     vi_ff     <= '0;
                     pmark_ff  <= '0;
                     vmark_ff  <= '0;
                     marked_ff <= 1'b0;
                     state_ff  <= ST_FETCH;
                  end
               end
            end
            ST_FETCH: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               state_ff <= ST_FETCH;
               if (v_in_range) begin
                  if (pc_is_run) begin
                     pi_ff     <= pi_ff + 1'b1;
                     pmark_ff  <= pi_ff + 1'b1;
                     vmark_ff  <= vi_ff;
                     marked_ff <= 1'b1;
                  end else if (pc_fits) begin
                     pi_ff <= pi_ff + 1'b1;
                     vi_ff <= vi_ff + 1'b1;
                  end else if (marked_ff && (vmark_ff < vlen_ff)) begin
                     vmark_ff <= vmark_ff + 1'b1;
                     vi_ff    <= vmark_ff + 1'b1;
                     pi_ff    <= pmark_ff;
                  end else begin
                     rsp_strobe_ff   <= 1'b1;
                     rsp_ff.matched  <= 1'b0;
                     rsp_ff.too_long <= 1'b0;
                     vlen_ff         <= '0;
                     state_ff        <= ST_IDLE;
                  end
               end else if (pc_is_run) begin
                  // skip trailing run wildcards
                  pi_ff <= pi_ff + 1'b1;
               end else begin
                  rsp_strobe_ff   <= 1'b1;
                  rsp_ff.matched  <= (pi_ff == plen_ff);
                  rsp_ff.too_long <= 1'b0;
                  vlen_ff         <= '0;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/lwm_checker.sv =====
// ----------------------------------------------------------------------------
// lwm_checker
// Port-level checks for the LIKE wildcard matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lwm_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       start,
   input wire                       busy,
   input wire lwm_pkg::lwm_req_type req_data,
   input wire                       rsp_strobe,
   input wire lwm_pkg::lwm_rsp_type rsp_data
);

   // overflow always forces a miss
   a_no_match_when_long: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.matched && rsp_data.too_long))
      else $error("matched reported together with too_long");

   // pattern requests never answer
   a_pattern_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.req_type == lwm_pkg::REQ_PATTERN)) |=> !rsp_strobe)
      else $error("response after a pattern request");

   // only the closing request of a value answers
   a_not_last_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_data.last) |=> !rsp_strobe)
      else $error("response after a request that is not last");

   // a response follows an accepted request or a running walk
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start && !busy) || $past(busy)))
      else $error("response without a request");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("not idle after reset");

endmodule

bind like_wildcard_match lwm_checker u_lwm_checker (.*);

`default_nettype wire
